>>> rtl/core/bic_pkg.sv
// Shared types, constants and helper functions of the burn-in care policy block.
package bic_pkg;

    localparam int unsigned TICK_MS      = 1000;
    localparam int unsigned MAX_NUDGE_PX = 16;
    localparam int unsigned PHASE_W      = $clog2(2 * MAX_NUDGE_PX);

    localparam int unsigned CFG_DW = 32;
    localparam int unsigned CFG_IW = 3;

    localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
    localparam logic [31:0] TICK_MS_W       = 32'(TICK_MS);
    localparam logic [31:0] SOAK_MS_PER_MIN = 32'd60000;

    localparam logic [31:0] DEF_NUDGE_MS = 32'd60000;
    localparam logic [31:0] DEF_DIM_MS   = 32'd300000;
    localparam logic [31:0] DEF_BLANK_MS = 32'd600000;
    localparam logic [31:0] DEF_WARN_MS  = 32'd7200000;
    localparam logic [6:0]  DEF_DIM_PCT  = 7'd20;
    localparam logic [4:0]  DEF_AMP_PX   = 5'd2;
    localparam logic [6:0]  DEF_APP_PCT  = 7'd100;
    localparam logic [6:0]  PCT_MAX      = 7'd100;
    localparam logic [4:0]  AMP_MAX      = 5'(MAX_NUDGE_PX);

    // Register indexes of the configuration port.
    localparam logic [CFG_IW-1:0] REG_NUDGE_MS = 3'd0;
    localparam logic [CFG_IW-1:0] REG_DIM_MS   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_BLANK_MS = 3'd2;
    localparam logic [CFG_IW-1:0] REG_WARN_MS  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_DIM_PCT  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_AMP_PX   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_APP_PCT  = 3'd6;
    localparam logic [CFG_IW-1:0] REG_BL       = 3'd7;

    // Command codes.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_TOUCH = 2'd1;
    localparam logic [1:0] CMD_SOAK  = 2'd2;

    typedef enum logic [2:0] {
        MODE_ACTIVE  = 3'd0,
        MODE_NUDGED  = 3'd1,
        MODE_DIMMED  = 3'd2,
        MODE_BLANKED = 3'd3,
        MODE_SOAKING = 3'd4
    } t_mode;

    // Effective configuration, with zero and oversize values already resolved.
    typedef struct packed {
        logic [31:0] nudge_ms;
        logic [31:0] dim_ms;
        logic [31:0] blank_ms;
        logic [31:0] warn_ms;
        logic [6:0]  dim_pct;
        logic [4:0]  amp_px;
        logic [6:0]  app_pct;
        logic        bl;
    } t_cfg;

    typedef struct packed {
        logic       vld;
        logic [6:0] pct;
    } t_app_wr;

    typedef struct packed {
        t_mode       mode;
        logic [4:0]  offset;
        logic [6:0]  backlight;
        logic        asleep;
        logic        fill;
        logic        warn;
        logic [31:0] still_ms;
        logic [31:0] soak_ms;
    } t_result;

    function automatic logic [6:0] pct_clip(input logic [6:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

    function automatic logic [31:0] sat_tick(input logic [31:0] a);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, TICK_MS_W};
        return s[32] ? ALL_ONES : s[31:0];
    endfunction

endpackage

>>> rtl/core/bic_cfg.sv
// Configuration registers of the burn-in care policy, stored in resolved form.
module bic_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bic_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [bic_pkg::CFG_DW-1:0] i_cfg_data,
    output bic_pkg::t_cfg              o_cfg,
    output bic_pkg::t_app_wr           o_app_wr
);
    import bic_pkg::*;

    t_cfg       r_cfg;
    logic [4:0] w_amp;
    logic [6:0] w_dim;

    always_comb begin
        w_amp = i_cfg_data[4:0];
        if (w_amp == 5'd0) begin
            w_amp = DEF_AMP_PX;
        end else if (w_amp > AMP_MAX) begin
            w_amp = AMP_MAX;
        end
        w_dim = (i_cfg_data[6:0] == 7'd0) ? DEF_DIM_PCT : pct_clip(i_cfg_data[6:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nudge_ms <= DEF_NUDGE_MS;
            r_cfg.dim_ms   <= DEF_DIM_MS;
            r_cfg.blank_ms <= DEF_BLANK_MS;
            r_cfg.warn_ms  <= DEF_WARN_MS;
            r_cfg.dim_pct  <= DEF_DIM_PCT;
            r_cfg.amp_px   <= DEF_AMP_PX;
            r_cfg.app_pct  <= DEF_APP_PCT;
            r_cfg.bl       <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUDGE_MS: r_cfg.nudge_ms <= (i_cfg_data == '0) ? DEF_NUDGE_MS : i_cfg_data;
                REG_DIM_MS:   r_cfg.dim_ms   <= (i_cfg_data == '0) ? DEF_DIM_MS : i_cfg_data;
                REG_BLANK_MS: r_cfg.blank_ms <= (i_cfg_data == '0) ? DEF_BLANK_MS : i_cfg_data;
                REG_WARN_MS:  r_cfg.warn_ms  <= (i_cfg_data == '0) ? DEF_WARN_MS : i_cfg_data;
                REG_DIM_PCT:  r_cfg.dim_pct  <= w_dim;
                REG_AMP_PX:   r_cfg.amp_px   <= w_amp;
                REG_APP_PCT:  r_cfg.app_pct  <= pct_clip(i_cfg_data[6:0]);
                REG_BL:       r_cfg.bl       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg        = r_cfg;
    assign o_app_wr.vld = i_cfg_we && (i_cfg_idx == REG_APP_PCT);
    assign o_app_wr.pct = pct_clip(i_cfg_data[6:0]);

endmodule

>>> rtl/core/bic_core.sv
// Policy state registers, next-state logic for one command, and the result register.
module bic_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [1:0]        i_cmd,
    input  logic [15:0]       i_soak_minutes,
    input  bic_pkg::t_cfg     i_cfg,
    input  bic_pkg::t_app_wr  i_app_wr,
    output bic_pkg::t_result  o_res
);
    import bic_pkg::*;

    localparam int unsigned PW = PHASE_W + 1;

    // Remainder by restoring subtraction; the period is at least two.
    function automatic logic [PHASE_W-1:0] phase_mod(input logic [PW-1:0] v,
                                                     input logic [PW-1:0] p);
        logic [PW-1:0]   r;
        logic [2*PW-1:0] sh;
        r = v;
        for (int k = PW - 2; k >= 0; k--) begin
            sh = {{PW{1'b0}}, p} << k;
            if ({{PW{1'b0}}, r} >= sh) begin
                r = r - sh[PW-1:0];
            end
        end
        return r[PHASE_W-1:0];
    endfunction

    t_mode              r_mode, n_mode;
    logic [31:0]        r_static, n_static;
    logic [31:0]        r_since, n_since;
    logic [31:0]        r_soak, n_soak;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [4:0]         r_offset, n_offset;
    logic               r_warned, n_warned;
    logic               r_asleep, n_asleep;
    logic [6:0]         r_bl_now, n_bl_now;
    t_result            r_res;

    logic               w_revive;
    logic               w_fill;
    logic               w_warn;
    logic [31:0]        w_st;
    logic [31:0]        w_sn;
    logic [PW-1:0]      w_period;
    logic [PW-1:0]      w_ph_inc;
    logic [PHASE_W-1:0] w_ph_new;
    logic [4:0]         w_off_new;
    logic [31:0]        w_soak_ms;

    always_comb begin
        w_st      = sat_tick(r_static);
        w_sn      = sat_tick(r_since);
        w_period  = PW'({1'b0, i_cfg.amp_px, 1'b0});
        w_ph_inc  = PW'({1'b0, r_phase}) + PW'(1);
        w_ph_new  = phase_mod(w_ph_inc, w_period);
        w_off_new = (PW'(w_ph_new) <= PW'(i_cfg.amp_px)) ? 5'(w_ph_new)
                                                          : 5'(w_period - PW'(w_ph_new));
        w_soak_ms = 32'({16'd0, i_soak_minutes} * SOAK_MS_PER_MIN);

        n_mode   = r_mode;
        n_static = r_static;
        n_since  = r_since;
        n_soak   = r_soak;
        n_phase  = r_phase;
        n_offset = r_offset;
        n_warned = r_warned;
        n_asleep = r_asleep;
        n_bl_now = r_bl_now;
        w_revive = 1'b0;
        w_fill   = 1'b0;
        w_warn   = 1'b0;

        case (i_cmd)
            CMD_TICK: begin
                n_static = w_st;
                n_since  = w_sn;
                if (r_mode == MODE_SOAKING) begin
                    n_soak = (r_soak > TICK_MS_W) ? r_soak - TICK_MS_W : 32'd0;
                    if (n_soak == 32'd0) begin
                        n_static = 32'd0;
                        n_since  = 32'd0;
                        w_revive = 1'b1;
                    end
                end else if (w_st >= i_cfg.blank_ms) begin
                    if (r_mode != MODE_BLANKED) begin
                        if (i_cfg.bl) begin
                            n_bl_now = 7'd0;
                        end
                        n_offset = 5'd0;
                        n_phase  = '0;
                        n_asleep = 1'b1;
                        n_mode   = MODE_BLANKED;
                    end
                end else begin
                    // Dimming only ever lowers the backlight.
                    if (w_st >= i_cfg.dim_ms && r_mode != MODE_DIMMED && i_cfg.bl) begin
                        if (i_cfg.dim_pct < i_cfg.app_pct) begin
                            n_bl_now = i_cfg.dim_pct;
                        end
                        n_mode = MODE_DIMMED;
                    end
                    if (i_cfg.nudge_ms != ALL_ONES && w_st >= i_cfg.nudge_ms
                            && w_sn >= i_cfg.nudge_ms) begin
                        n_phase  = w_ph_new;
                        n_offset = w_off_new;
                        n_since  = 32'd0;
                        if (n_mode == MODE_ACTIVE) begin
                            n_mode = MODE_NUDGED;
                        end
                    end
                    if (!r_warned && i_cfg.warn_ms != ALL_ONES && w_st >= i_cfg.warn_ms) begin
                        n_warned = 1'b1;
                        w_warn   = 1'b1;
                    end
                end
            end
            CMD_TOUCH: begin
                n_static = 32'd0;
                n_since  = 32'd0;
                n_warned = 1'b0;
                if (r_mode != MODE_SOAKING) begin
                    w_revive = 1'b1;
                end
            end
            CMD_SOAK: begin
                if (i_soak_minutes == 16'd0) begin
                    if (r_mode == MODE_SOAKING) begin
                        w_revive = 1'b1;
                    end
                end else begin
                    if (i_cfg.bl) begin
                        n_bl_now = 7'd0;
                    end
                    n_asleep = 1'b0;
                    n_offset = 5'd0;
                    n_phase  = '0;
                    n_mode   = MODE_SOAKING;
                    n_soak   = w_soak_ms;
                    w_fill   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Reviving is always the last state change of a command.
        if (w_revive) begin
            if (r_offset != 5'd0) begin
                n_offset = 5'd0;
                n_phase  = '0;
            end
            n_asleep = 1'b0;
            if (i_cfg.bl && r_mode != MODE_ACTIVE) begin
                n_bl_now = i_cfg.app_pct;
            end
            n_mode = MODE_ACTIVE;
            n_soak = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ACTIVE;
            r_static <= 32'd0;
            r_since  <= 32'd0;
            r_soak   <= 32'd0;
            r_phase  <= '0;
            r_offset <= 5'd0;
            r_warned <= 1'b0;
            r_asleep <= 1'b0;
            r_bl_now <= DEF_APP_PCT;
        end else if (i_en) begin
            r_mode   <= n_mode;
            r_static <= n_static;
            r_since  <= n_since;
            r_soak   <= n_soak;
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_warned <= n_warned;
            r_asleep <= n_asleep;
            r_bl_now <= n_bl_now;
        end else if (i_app_wr.vld && i_cfg.bl
                     && (r_mode == MODE_ACTIVE || r_mode == MODE_NUDGED)) begin
            // An app level write is kept while not dimmed or dark and no step runs.
            r_bl_now <= i_app_wr.pct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.mode      <= n_mode;
            r_res.offset    <= n_offset;
            r_res.backlight <= n_bl_now;
            r_res.asleep    <= n_asleep;
            r_res.fill      <= w_fill;
            r_res.warn      <= w_warn;
            r_res.still_ms  <= n_static;
            r_res.soak_ms   <= n_soak;
        end
    end

    assign o_res = r_res;

endmodule

>>> rtl/core/display_burn_in_care_policy.sv
// A transaction accepted into the input register passes through the policy update
// and is held in the result register, from which the receiver takes it.
// Throughput: one command per cycle while the output is not stalled; the input
// register takes a new transaction every cycle while the result register drains.
// Reset is synchronous and active low: it empties the pipeline, returns the policy
// state to active with cleared counters, and loads the register defaults.
module display_burn_in_care_policy (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_cmd,
    input  logic [15:0]                i_soak_minutes,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [2:0]                 o_mode,
    output logic [4:0]                 o_scroll_offset,
    output logic [6:0]                 o_backlight_level,
    output logic                       o_panel_asleep,
    output logic                       o_fill_black,
    output logic                       o_warn_pulse,
    output logic [31:0]                o_static_ms,
    output logic [31:0]                o_soak_remaining_ms,
    input  logic                       i_cfg_we,
    input  logic [bic_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [bic_pkg::CFG_DW-1:0] i_cfg_data
);
    import bic_pkg::*;

    t_cfg        w_cfg;
    t_app_wr     w_app_wr;
    t_result     w_res;

    logic        r_s1_vld, n_s1_vld;
    logic [1:0]  r_s1_cmd;
    logic [15:0] r_s1_min;
    logic        r_out_vld, n_out_vld;
    logic        w_adv;
    logic        w_in_acc;
    logic        w_step;

    // The input register moves on whenever the result register is free or being taken.
    assign w_adv      = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_step     = r_s1_vld && w_adv;
    assign n_s1_vld   = w_in_acc || (r_s1_vld && !w_adv);
    assign n_out_vld  = w_step || (r_out_vld && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_cmd <= i_cmd;
            r_s1_min <= i_soak_minutes;
        end
    end

    bic_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_app_wr   (w_app_wr)
    );

    bic_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_step),
        .i_cmd          (r_s1_cmd),
        .i_soak_minutes (r_s1_min),
        .i_cfg          (w_cfg),
        .i_app_wr       (w_app_wr),
        .o_res          (w_res)
    );

    assign o_out_valid         = r_out_vld;
    assign o_mode              = w_res.mode;
    assign o_scroll_offset     = w_res.offset;
    assign o_backlight_level   = w_res.backlight;
    assign o_panel_asleep      = w_res.asleep;
    assign o_fill_black        = w_res.fill;
    assign o_warn_pulse        = w_res.warn;
    assign o_static_ms         = w_res.still_ms;
    assign o_soak_remaining_ms = w_res.soak_ms;

endmodule
